@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
// Each macro expands to one labeled concurrent assertion clocked on the rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

@@ design/byuv_pkg.sv @@
// Shared types, constants and the Bayer source table for the Bayer to YUV 4:2:0 converter.
// No dependencies; every other design module imports this package.
`timescale 1ns / 1ps

package byuv_pkg;

	localparam int MAX_WIDTH = 4096;
	localparam int MAX_ROWS = 4096;
	localparam int PIX_W = 8;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int CFG_W = 13;
	localparam int IDX_W = 8;
	localparam int SEL_W = 4;

	// Division by three through a reciprocal: floor(w / 3) == (w * 2731) >> 13 for w <= 4096.
	localparam int RECIP_W = 12;
	localparam int DIV3_SHIFT = 13;
	localparam logic [RECIP_W-1:0] DIV3_RECIP = 12'd2731;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam int SUM_W = 18;
	localparam logic signed [SUM_W-1:0] Y_R = 18'sd64;
	localparam logic signed [SUM_W-1:0] Y_G = 18'sd128;
	localparam logic signed [SUM_W-1:0] Y_B = 18'sd25;
	localparam logic signed [SUM_W-1:0] U_R = -18'sd38;
	localparam logic signed [SUM_W-1:0] U_G = -18'sd74;
	localparam logic signed [SUM_W-1:0] U_B = 18'sd112;
	localparam logic signed [SUM_W-1:0] V_R = 18'sd112;
	localparam logic signed [SUM_W-1:0] V_G = -18'sd94;
	localparam logic signed [SUM_W-1:0] V_B = -18'sd18;
	localparam logic signed [SUM_W-1:0] Y_OFF = 18'sd16;
	localparam logic signed [SUM_W-1:0] C_OFF = 18'sd128;

	localparam logic [1:0] RST_BAYER_ORDER = 2'd0;
	localparam logic RST_CHROMA_ORDER = 1'b0;
	localparam logic [CFG_W-1:0] RST_ROW_WIDTH = 13'd1280;
	localparam logic [CFG_W-1:0] RST_ROW_COUNT = 13'd720;

	typedef enum logic [IDX_W-1:0] {
		REG_BAYER_ORDER  = 8'd0,
		REG_CHROMA_ORDER = 8'd1,
		REG_ROW_WIDTH    = 8'd2,
		REG_ROW_COUNT    = 8'd3
	} cfg_reg_t;

	// Window sample positions: 0 top-left, 1 top-right, 2 bottom-left, 3 bottom-right.
	// Each entry packs the R, G and B positions, two bits each, R in the top bits.
	localparam logic [5:0] SRC_TAB [16] = '{
		6'b11_01_00, 6'b10_00_01, 6'b01_00_11, 6'b00_01_11,
		6'b01_00_10, 6'b00_01_11, 6'b11_01_00, 6'b10_01_00,
		6'b00_01_11, 6'b01_00_10, 6'b10_00_01, 6'b11_01_00,
		6'b10_00_01, 6'b11_01_00, 6'b00_01_11, 6'b01_00_10
	};

	typedef struct packed {
		logic [PIX_W-1:0] raw_pixel;
		logic             start_of_frame;
	} sample_t;

	typedef struct packed {
		logic [PIX_W-1:0] luma;
		logic [PIX_W-1:0] chroma;
		logic             chroma_present;
		logic             chroma_is_v;
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
		logic             frame_end;
	} result_t;

	typedef struct packed {
		logic [1:0]       bayer_order;
		logic             chroma_order;
		logic [CFG_W-1:0] row_width;
		logic [CFG_W-1:0] row_count;
	} cfg_t;

	// One classified window waiting for the color math.
	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic             chroma_present;
		logic             chroma_is_v;
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
		logic             frame_end;
	} rgb_item_t;

endpackage

@@ design/bayer_to_yuv420_semiplanar_top.sv @@
// Top level of the Bayer to YUV 4:2:0 converter: configuration registers and the
// front end, window queue and back end. Depends on byuv_pkg and the three submodules.
`timescale 1ns / 1ps

// Usage:
// Raw Bayer bytes enter in raster order through a queue-style port: a transaction
// completes when push is high and full is low. start_of_frame marks column 0, row 0.
// Each sample that completes a 2x2 window in the frame's first 2*floor(width/3) - 1
// columns yields one result with luma and, on even window rows, one U or V byte;
// other samples yield nothing. Results leave through a queue-style port: the oldest
// result is shown while empty is low and is taken when pop is high.
// A result passes the front stage, window queue, color stage and output register.
// Throughput: one sample per cycle while full is low; one line store read and write
// per sample at the same column; the color math is a two-stage pipeline.
// A stalled receiver fills the output register and the color pipeline stage, then
// the four-entry window queue; the next window then waits in the front stage and
// full rises to hold off the source.
// Configuration writes complete whenever cfg_valid is high (cfg_ready is always high)
// and must only happen while no transaction is in flight.
// Reset clears counters, pipeline state and queues and loads the register defaults;
// the line store holds no data until its first row has been written.

module bayer_to_yuv420_semiplanar_top (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  byuv_pkg::sample_t       sample,
	output logic                    empty,
	input  logic                    pop,
	output byuv_pkg::result_t       result,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [byuv_pkg::IDX_W-1:0] cfg_index,
	input  logic [byuv_pkg::CFG_W-1:0] cfg_data
);
	import byuv_pkg::*;

	cfg_t      cfg_q;
	logic      q_push;
	logic      q_full;
	logic      q_pop;
	logic      q_empty;
	rgb_item_t q_wr_item;
	rgb_item_t q_rd_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bayer_order  <= RST_BAYER_ORDER;
			cfg_q.chroma_order <= RST_CHROMA_ORDER;
			cfg_q.row_width    <= RST_ROW_WIDTH;
			cfg_q.row_count    <= RST_ROW_COUNT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BAYER_ORDER:  cfg_q.bayer_order  <= cfg_data[1:0];
				REG_CHROMA_ORDER: cfg_q.chroma_order <= cfg_data[0];
				REG_ROW_WIDTH:    cfg_q.row_width    <= cfg_data;
				REG_ROW_COUNT:    cfg_q.row_count    <= cfg_data;
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	byuv_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.sample (sample),
		.cfg    (cfg_q),
		.q_push (q_push),
		.q_full (q_full),
		.q_item (q_wr_item)
	);

	byuv_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.is_full  (q_full),
		.wr_data  (q_wr_item),
		.rd_en    (q_pop),
		.is_empty (q_empty),
		.rd_data  (q_rd_item)
	);

	byuv_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.q_item  (q_rd_item),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

@@ design/byuv_front.sv @@
// Front end: raster counters, window classification, line store and RGB pick.
// Depends on byuv_pkg; feeds the window queue.
`timescale 1ns / 1ps

module byuv_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  byuv_pkg::sample_t   sample,
	input  byuv_pkg::cfg_t      cfg,
	output logic                q_push,
	input  logic                q_full,
	output byuv_pkg::rgb_item_t q_item
);
	import byuv_pkg::*;

	logic                      accept;
	logic [COL_W-1:0]          col_q;
	logic [ROW_W-1:0]          row_q;
	logic [COL_W-1:0]          c_cur;
	logic [ROW_W-1:0]          r_cur;
	logic [CFG_W-1:0]          c_ext;
	logic [CFG_W-1:0]          r_ext;
	logic [CFG_W-1:0]          w_eff;
	logic [CFG_W-1:0]          h_eff;
	logic [CFG_W+RECIP_W-1:0]  third_full;
	logic [CFG_W-1:0]          iw;
	logic                      col_ok;
	logic                      row_ok;
	logic                      last_win;
	logic                      col_wrap;
	logic                      row_wrap;
	logic                      x_odd;
	logic                      y_odd;

	logic                      valid_s1;
	logic                      prod_s1;
	logic [PIX_W-1:0]          pix_s1;
	logic [PIX_W-1:0]          old_s1;
	logic [SEL_W-1:0]          sel_s1;
	logic                      present_s1;
	logic                      is_v_s1;
	logic [COL_W-1:0]          column_s1;
	logic [ROW_W-1:0]          row_s1;
	logic                      frame_end_s1;
	logic                      adv_s1;

	logic [PIX_W-1:0]          above_left_q;
	logic [PIX_W-1:0]          left_pixel_q;
	logic [PIX_W-1:0]          line_mem [MAX_WIDTH];
	logic [PIX_W-1:0]          win [4];
	logic [5:0]                src;

	// A window that must go to the queue holds stage one while the queue is full.
	assign adv_s1 = valid_s1 && !(prod_s1 && q_full);
	assign full   = valid_s1 && prod_s1 && q_full;
	assign accept = push && !full;

	assign c_cur = sample.start_of_frame ? '0 : col_q;
	assign r_cur = sample.start_of_frame ? '0 : row_q;
	assign c_ext = {{(CFG_W-COL_W){1'b0}}, c_cur};
	assign r_ext = {{(CFG_W-ROW_W){1'b0}}, r_cur};

	always_comb begin
		w_eff = (cfg.row_width > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : cfg.row_width;
		h_eff = (cfg.row_count > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : cfg.row_count;
		third_full = {{RECIP_W{1'b0}}, w_eff} * {{CFG_W{1'b0}}, DIV3_RECIP};
		iw = {third_full[DIV3_SHIFT +: CFG_W-1], 1'b0};
		col_ok = (iw >= CFG_W'(3)) && (c_ext != '0) && (c_ext <= iw - CFG_W'(2));
		row_ok = (r_ext != '0) && ((h_eff == '0) || (r_ext < h_eff));
		last_win = (h_eff >= CFG_W'(2)) && (r_ext == h_eff - CFG_W'(1))
			&& (c_ext == iw - CFG_W'(2));
		col_wrap = (w_eff == '0) || (c_ext + CFG_W'(1) >= w_eff);
		row_wrap = (h_eff == '0) || (r_ext + CFG_W'(1) >= h_eff);
		// The window's top-left corner is one column left and one row up.
		x_odd = ~c_cur[0];
		y_odd = ~r_cur[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : r_cur + ROW_W'(1);
			end else begin
				col_q <= c_cur + COL_W'(1);
				row_q <= r_cur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			prod_s1  <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			prod_s1  <= col_ok && row_ok;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
			prod_s1  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1       <= sample.raw_pixel;
			sel_s1       <= {cfg.bayer_order, y_odd, x_odd};
			present_s1   <= !y_odd;
			is_v_s1      <= !y_odd && (1'b1 ^ x_odd ^ cfg.chroma_order);
			column_s1    <= c_cur - COL_W'(1);
			row_s1       <= r_cur - ROW_W'(1);
			frame_end_s1 <= last_win;
		end
	end

	// Line store: read-before-write at the current column.
	always_ff @(posedge clk) begin
		if (accept) begin
			old_s1 <= line_mem[c_cur];
			line_mem[c_cur] <= sample.raw_pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_left_q <= '0;
			left_pixel_q <= '0;
		end else if (adv_s1) begin
			above_left_q <= old_s1;
			left_pixel_q <= pix_s1;
		end
	end

	always_comb begin
		win[0] = above_left_q;
		win[1] = old_s1;
		win[2] = left_pixel_q;
		win[3] = pix_s1;
		src = SRC_TAB[sel_s1];
		q_item.red            = win[src[5:4]];
		q_item.green          = win[src[3:2]];
		q_item.blue           = win[src[1:0]];
		q_item.chroma_present = present_s1;
		q_item.chroma_is_v    = is_v_s1;
		q_item.column         = column_s1;
		q_item.row            = row_s1;
		q_item.frame_end      = frame_end_s1;
	end

	assign q_push = valid_s1 && prod_s1 && !q_full;

endmodule

@@ design/byuv_fifo.sv @@
// Short window queue between the front end and the color math.
// Depends on byuv_pkg for the entry type and depth.
`timescale 1ns / 1ps

module byuv_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	output logic                is_full,
	input  byuv_pkg::rgb_item_t wr_data,
	input  logic                rd_en,
	output logic                is_empty,
	output byuv_pkg::rgb_item_t rd_data
);
	import byuv_pkg::*;

	rgb_item_t         slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign is_full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign is_empty = (count_q == '0);
	assign rd_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ design/byuv_back.sv @@
// Back end: luma and chroma sums, shift, offset and clamp, and the result register.
// Depends on byuv_pkg; drains the window queue.
`timescale 1ns / 1ps

module byuv_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	output logic                q_pop,
	input  byuv_pkg::rgb_item_t q_item,
	output logic                empty,
	input  logic                pop,
	output byuv_pkg::result_t   result
);
	import byuv_pkg::*;

	logic signed [SUM_W-1:0] rs;
	logic signed [SUM_W-1:0] gs;
	logic signed [SUM_W-1:0] bs;
	logic signed [SUM_W-1:0] cr;
	logic signed [SUM_W-1:0] cg;
	logic signed [SUM_W-1:0] cb;
	logic signed [SUM_W-1:0] luma_sum;
	logic signed [SUM_W-1:0] chroma_sum;

	logic                    valid_s1;
	logic signed [SUM_W-1:0] luma_sum_s1;
	logic signed [SUM_W-1:0] chroma_sum_s1;
	logic                    present_s1;
	logic                    is_v_s1;
	logic [COL_W-1:0]        column_s1;
	logic [ROW_W-1:0]        row_s1;
	logic                    frame_end_s1;

	logic signed [SUM_W-1:0] luma_val;
	logic signed [SUM_W-1:0] chroma_val;
	logic                    out_valid_q;
	result_t                 result_q;
	logic                    ready_s2;
	logic                    ready_s1;

	assign ready_s2 = !out_valid_q || pop;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign q_pop    = !q_empty && ready_s1;
	assign empty    = !out_valid_q;
	assign result   = result_q;

	always_comb begin
		rs = SUM_W'($signed({1'b0, q_item.red}));
		gs = SUM_W'($signed({1'b0, q_item.green}));
		bs = SUM_W'($signed({1'b0, q_item.blue}));
		cr = q_item.chroma_is_v ? V_R : U_R;
		cg = q_item.chroma_is_v ? V_G : U_G;
		cb = q_item.chroma_is_v ? V_B : U_B;
		luma_sum   = Y_R * rs + Y_G * gs + Y_B * bs;
		chroma_sum = cr * rs + cg * gs + cb * bs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= q_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			luma_sum_s1   <= luma_sum;
			chroma_sum_s1 <= chroma_sum;
			present_s1    <= q_item.chroma_present;
			is_v_s1       <= q_item.chroma_is_v;
			column_s1     <= q_item.column;
			row_s1        <= q_item.row;
			frame_end_s1  <= q_item.frame_end;
		end
	end

	// Arithmetic shift floors negative chroma sums.
	always_comb begin
		luma_val   = (luma_sum_s1 >>> 8) + Y_OFF;
		chroma_val = (chroma_sum_s1 >>> 8) + C_OFF;
		if (chroma_val < 0) begin
			chroma_val = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_s2) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			result_q.luma           <= luma_val[PIX_W-1:0];
			result_q.chroma         <= present_s1 ? chroma_val[PIX_W-1:0] : '0;
			result_q.chroma_present <= present_s1;
			result_q.chroma_is_v    <= is_v_s1;
			result_q.column         <= column_s1;
			result_q.row            <= row_s1;
			result_q.frame_end      <= frame_end_s1;
		end
	end

endmodule

@@ design/byuv_checker.sv @@
// Port-level checker for the Bayer to YUV 4:2:0 converter, bound to its top level.
// Depends on byuv_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module byuv_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         push,
	input logic                         full,
	input byuv_pkg::sample_t            sample,
	input logic                         empty,
	input logic                         pop,
	input byuv_pkg::result_t            result,
	input logic                         cfg_valid,
	input logic                         cfg_ready,
	input logic [byuv_pkg::IDX_W-1:0]   cfg_index,
	input logic [byuv_pkg::CFG_W-1:0]   cfg_data
);
	import byuv_pkg::*;

	// A shown result that is not taken stays unchanged.
	`CHK_NEXT(a_result_held, clk, arst_n, !empty && !pop, !empty && $stable(result))

	// Odd window rows carry no chroma byte.
	`CHK_IMPLY(a_odd_row_no_chroma, clk, arst_n, !empty && result.row[0], !result.chroma_present && result.chroma == 8'd0 && !result.chroma_is_v)

	// Even window rows always carry a chroma byte.
	`CHK_IMPLY(a_even_row_chroma, clk, arst_n, !empty && !result.row[0], result.chroma_present)

	// Luma of 8-bit samples stays within the video range of the formula.
	`CHK_IMPLY(a_luma_range, clk, arst_n, !empty, result.luma >= 8'd16 && result.luma <= 8'd232)

endmodule

bind bayer_to_yuv420_semiplanar_top byuv_checker u_byuv_checker (.*);

@@ test/bayer_to_yuv420_semiplanar_top_tb.sv @@
// Self-checking testbench for bayer_to_yuv420_semiplanar_top: streams raw Bayer frames,
// predicts each YUV window result and checks it. Depends on byuv_pkg and the design files.
`timescale 1ns / 1ps

module bayer_to_yuv420_semiplanar_top_tb;
	import byuv_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	sample_t sample = '0;
	logic empty;
	logic pop = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	bayer_to_yuv420_semiplanar_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.sample(sample),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("bayer_to_yuv420_semiplanar_top regression: fail");
		$finish;
	end

	// Window sample positions: 0 top-left, 1 top-right, 2 bottom-left, 3 bottom-right.
	// Indexed by bayer order * 4 + column parity + 2 * row parity.
	int red_from [16] = '{3, 2, 1, 0, 1, 0, 3, 2, 0, 1, 2, 3, 2, 3, 0, 1};
	int green_from [16] = '{1, 0, 0, 1, 0, 1, 1, 1, 1, 0, 0, 1, 0, 1, 1, 0};
	int blue_from [16] = '{0, 1, 3, 3, 2, 3, 0, 0, 3, 2, 1, 0, 1, 0, 3, 2};

	// Predictor state and its copy of the registers.
	logic [7:0] line_mem [4096];
	logic [7:0] above_left = '0;
	logic [7:0] left_pix = '0;
	int col_cnt = 0;
	int row_idx = 0;
	logic [1:0] bayer_sel = 2'd0;
	logic chroma_swap = 1'b0;
	logic [CFG_W-1:0] width_reg = 13'd1280;
	logic [CFG_W-1:0] rows_reg = 13'd720;

	result_t yuv_expected [$];
	int mismatches = 0;
	int samples_sent = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int rx_hold_left = 0;

	function automatic bit predict_window(input logic [7:0] pix, input logic sof,
			output result_t res);
		int w, h, iw, c, r, x, y, sel, red, grn, blu, chr;
		logic [7:0] old;
		logic [7:0] win [4];
		bit hit;
		w = (width_reg > 4096) ? 4096 : int'(width_reg);
		h = (rows_reg > 4096) ? 4096 : int'(rows_reg);
		iw = (w / 3) * 2;
		if (sof) begin
			col_cnt = 0;
			row_idx = 0;
		end
		c = col_cnt;
		r = row_idx;
		old = line_mem[c];
		res = '0;
		hit = (r >= 1) && (c >= 1) && (iw >= 3) && (c - 1 <= iw - 3) && (r <= h - 1);
		if (hit) begin
			x = c - 1;
			y = r - 1;
			sel = int'(bayer_sel) * 4 + (x % 2) + 2 * (y % 2);
			win[0] = above_left;
			win[1] = old;
			win[2] = left_pix;
			win[3] = pix;
			red = win[red_from[sel]];
			grn = win[green_from[sel]];
			blu = win[blue_from[sel]];
			res.luma = 8'(((64 * red + 128 * grn + 25 * blu) >> 8) + 16);
			if (y % 2 == 0) begin
				res.chroma_present = 1'b1;
				// V lands on even columns unless the chroma order swaps it.
				res.chroma_is_v = ((x % 2) == int'(chroma_swap));
				if (res.chroma_is_v)
					chr = ((112 * red - 94 * grn - 18 * blu) >>> 8) + 128;
				else
					chr = ((-38 * red - 74 * grn + 112 * blu) >>> 8) + 128;
				if (chr < 0)
					chr = 0;
				res.chroma = 8'(chr);
			end
			res.column = 12'(x);
			res.row = 12'(y);
			res.frame_end = (y == h - 2) && (x == iw - 3);
		end
		line_mem[c] = pix;
		above_left = old;
		left_pix = pix;
		if (c + 1 >= w) begin
			col_cnt = 0;
			row_idx = (r + 1 >= h) ? 0 : ((r + 1) & 12'hFFF);
		end else begin
			col_cnt = (c + 1) & 12'hFFF;
		end
		return hit;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want,
			input int col, input int row);
		mismatches++;
		$display("mismatch at %0t: %s got %0d expected %0d (window %0d,%0d)",
			$time, what, got, want, col, row);
	endtask

	// Receiver: random stalls, plus a counted hold-off that a test can request.
	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			rx_hold_left <= rx_hold_left - 1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin : check_result
		result_t want;
		if (arst_n && pop && !empty) begin
			if (yuv_expected.size() == 0) begin
				report_mismatch("unexpected result", result.luma, 0, result.column,
					result.row);
			end else begin
				want = yuv_expected.pop_front();
				if (result.luma !== want.luma)
					report_mismatch("luma", result.luma, want.luma, want.column, want.row);
				if (result.chroma !== want.chroma)
					report_mismatch("chroma", result.chroma, want.chroma, want.column,
						want.row);
				if (result.chroma_present !== want.chroma_present)
					report_mismatch("chroma_present", result.chroma_present,
						want.chroma_present, want.column, want.row);
				if (result.chroma_is_v !== want.chroma_is_v)
					report_mismatch("chroma_is_v", result.chroma_is_v, want.chroma_is_v,
						want.column, want.row);
				if (result.column !== want.column)
					report_mismatch("column", result.column, want.column, want.column,
						want.row);
				if (result.row !== want.row)
					report_mismatch("row", result.row, want.row, want.column, want.row);
				if (result.frame_end !== want.frame_end)
					report_mismatch("frame_end", result.frame_end, want.frame_end,
						want.column, want.row);
			end
		end
	end

	// All tasks below start and end at a falling edge.
	task automatic send_sample(input logic [7:0] pix, input logic sof);
		result_t want;
		while ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		sample <= {pix, sof};
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (predict_window(pix, sof, want))
			yuv_expected.push_back(want);
		samples_sent++;
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_pixel();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_frame(input int count);
		for (int i = 0; i < count; i++)
			send_sample(pick_pixel(), i == 0);
	endtask

	// Waits until every predicted result has been taken, then lets the pipeline settle
	// so that a sample producing no result is also out of the block.
	task automatic drain_results();
		push <= 1'b0;
		while (yuv_expected.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	// Writes one register and leaves cfg_valid high; the caller drops it at the end.
	task automatic write_reg(input cfg_reg_t idx, input int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_BAYER_ORDER: bayer_sel = 2'(val);
			REG_CHROMA_ORDER: chroma_swap = 1'(val);
			REG_ROW_WIDTH: width_reg = CFG_W'(val);
			REG_ROW_COUNT: rows_reg = CFG_W'(val);
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_config(input int order, input int corder, input int width,
			input int rows);
		drain_results();
		write_reg(REG_BAYER_ORDER, order);
		write_reg(REG_CHROMA_ORDER, corder);
		write_reg(REG_ROW_WIDTH, width);
		write_reg(REG_ROW_COUNT, rows);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_size(input int width, input int rows);
		drain_results();
		write_reg(REG_ROW_WIDTH, width);
		write_reg(REG_ROW_COUNT, rows);
		cfg_valid <= 1'b0;
	endtask

	// Register defaults: the counters start at zero, so no frame marker is needed, and
	// the start of a default-width row gives no result. A small frame then runs with
	// the color and chroma orders still at their reset values.
	task automatic test_reset_defaults();
		for (int i = 0; i < 40; i++)
			send_sample(pick_pixel(), 1'b0);
		set_size(8, 3);
		send_frame(24);
	endtask

	// Every Bayer order with both chroma orders; a 6x3 frame covers all four parities.
	task automatic test_color_orders();
		for (int order = 0; order < 4; order++)
			for (int corder = 0; corder < 2; corder++) begin
				set_config(order, corder, 6, 3);
				send_frame(18);
			end
	endtask

	// Widths below six give no window at all; six with two rows is the smallest frame.
	task automatic test_small_sizes();
		set_config(1, 0, 4, 2);
		send_frame(16);
		set_config(2, 1, 5, 2);
		send_frame(10);
		set_config(3, 0, 6, 2);
		send_frame(24);
	endtask

	// Counters wrap by themselves; a frame marker in the middle of a row restarts.
	task automatic test_free_running();
		set_config(2, 0, 7, 3);
		send_frame(7 * 3 * 2 + 10);
		send_frame(7 * 3);
	endtask

	task automatic test_backpressure();
		set_config(1, 1, 10, 6);
		rx_hold_left = 60;
		send_frame(60);
		// The source pauses here until the receiver has taken everything.
		drain_results();
		rx_hold_left = 40;
		send_frame(60);
	endtask

	task automatic test_long_row();
		set_config($urandom_range(3), $urandom_range(1), 130, 2);
		send_frame(130 * 2);
	endtask

	task automatic test_tallest_frame();
		set_config($urandom_range(3), $urandom_range(1), 6, 4096);
		send_frame(180);
	endtask

	// Mostly whole frames with random content, some cut short, some stray samples.
	task automatic test_random_stream(input int idle_pct, input int stall_pct,
			input int count);
		int first, w, h, kind, len;
		tx_idle_pct = idle_pct;
		rx_stall_pct = stall_pct;
		first = samples_sent;
		kind = 0;
		while (samples_sent - first < count) begin
			if (kind == 0) begin
				case ($urandom_range(9))
					0: w = $urandom_range(4, 5);
					1: w = $urandom_range(25, 64);
					default: w = $urandom_range(6, 24);
				endcase
				h = ($urandom_range(4) == 0) ? $urandom_range(7, 12) : $urandom_range(2, 6);
				set_config($urandom_range(3), $urandom_range(1), w, h);
				// A new width needs a fresh frame before any row is read back.
				send_frame(w * h);
			end else if (kind <= 6) begin
				send_frame(int'(width_reg) * int'(rows_reg));
			end else if (kind <= 8) begin
				send_frame($urandom_range(1, int'(width_reg) * int'(rows_reg)));
			end else begin
				len = $urandom_range(1, 2 * int'(width_reg));
				for (int i = 0; i < len; i++)
					send_sample(8'($urandom_range(255)), $urandom_range(15) == 0);
			end
			kind = $urandom_range(10);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_color_orders();
		test_small_sizes();
		test_free_running();
		test_backpressure();
		test_long_row();
		test_tallest_frame();
		test_random_stream(0, 0, 120);
		test_random_stream(70, 0, 120);
		test_random_stream(0, 70, 120);
		test_random_stream(24, 24, 120);
		drain_results();
		if (mismatches == 0 && yuv_expected.size() == 0)
			$display("bayer_to_yuv420_semiplanar_top regression: pass");
		else
			$display("bayer_to_yuv420_semiplanar_top regression: fail");
		$finish;
	end

endmodule
